// ===== rtl/core/fft_pkg.sv =====
// shared types, constants and field widths of the first-fit free extent table
package fft_pkg;

	localparam int DEF_TABLE_DEPTH  = 64;
	localparam int DEF_OFFSET_WIDTH = 32;

	localparam int LEN_W     = 16;
	localparam int XOFF_W    = 32;
	localparam int XSIZE_W   = 17;
	localparam int SIZE_W    = 32;
	localparam int NEED_W    = 17;
	localparam int STATUS_W  = 3;
	localparam int POS_W     = 32;
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 40;

	localparam int HDR_BYTES    = 4;
	localparam int MIN_LEFTOVER = 5;

	typedef enum logic [STATUS_W-1:0] {
		STAT_EXACT   = 3'd0,
		STAT_SPLIT   = 3'd1,
		STAT_APPEND  = 3'd2,
		STAT_NEWFREE = 3'd3,
		STAT_MERGED  = 3'd4,
		STAT_MISSING = 3'd5,
		STAT_FULL    = 3'd6
	} status_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

endpackage

// ===== rtl/core/fft_ram.sv =====
// generic simple dual-port ram with registered read
module fft_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/fft_alu.sv =====
// shared add / subtract unit, result carries one extra bit (carry or borrow)
module fft_alu #(
	parameter int AW = 32
) (
	input  fft_pkg::alu_op_t op,
	input  logic [AW-1:0]    a,
	input  logic [AW-1:0]    b,
	output logic [AW:0]      res
);

	always_comb begin
		case (op)
			fft_pkg::ALU_ADD: res = {1'b0, a} + {1'b0, b};
			fft_pkg::ALU_SUB: res = {1'b0, a} - {1'b0, b};
			default:          res = '0;
		endcase
	end

endmodule

// ===== rtl/core/first_fit_free_extent_table.sv =====
// first-fit free extent table: allocate with exact fit / split / append, free with merge or a new free entry
// one transfer in flight: the table ram has one read and one write port, which sets the rate
// the next transfer is taken once the sequencer is idle, the result may still wait on m_axis
// arst_n clears the sequencer, entry count and end pointer; table contents stay unset
module first_fit_free_extent_table #(
	parameter int TABLE_DEPTH  = fft_pkg::DEF_TABLE_DEPTH,
	parameter int OFFSET_WIDTH = fft_pkg::DEF_OFFSET_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// record_length, extent_offset, extent_size, next_is_free, zero fill
	input  logic [fft_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// mode
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// status, position, zero fill
	output logic [fft_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int OW = OFFSET_WIDTH;
	localparam int EW = OFFSET_WIDTH + fft_pkg::SIZE_W;
	localparam int AW = (OFFSET_WIDTH > fft_pkg::SIZE_W) ? OFFSET_WIDTH : fft_pkg::SIZE_W;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_PREP    = 9'b000000010,
		S_SCAN    = 9'b000000100,
		S_SHIFT   = 9'b000001000,
		S_SPLIT   = 9'b000010000,
		S_APPEND  = 9'b000100000,
		S_MERGE   = 9'b001000000,
		S_NEWFREE = 9'b010000000,
		S_DONE    = 9'b100000000
	} state_t;

	state_t state_q;

	// request fields
	logic                              free_q;
	logic [fft_pkg::NEED_W-1:0]        need_q;
	logic [OW-1:0]                     off_in_q;
	logic [fft_pkg::XSIZE_W-1:0]       size_in_q;
	logic [OW-1:0]                     target_q;

	// table control
	logic [CW-1:0]                     count_q;
	logic [OW-1:0]                     end_q;
	logic [CW-1:0]                     idx_q;
	logic                              chk_q;
	logic [IW-1:0]                     chk_idx_q;
	logic [IW-1:0]                     hit_idx_q;
	logic [OW-1:0]                     offset_q;
	logic [fft_pkg::SIZE_W-1:0]        size_q;

	// result
	fft_pkg::status_t                  status_q;
	logic [fft_pkg::POS_W-1:0]         pos_q;
	logic                              out_valid_q;
	fft_pkg::status_t                  out_status_q;
	logic [fft_pkg::POS_W-1:0]         out_pos_q;

	// ram ports
	logic                              ram_we;
	logic [IW-1:0]                     ram_waddr;
	logic [EW-1:0]                     ram_wdata;
	logic                              ram_re;
	logic [IW-1:0]                     ram_raddr;
	logic [EW-1:0]                     ram_rdata;
	logic [OW-1:0]                     rd_off;
	logic [fft_pkg::SIZE_W-1:0]        rd_size;

	// shared unit
	fft_pkg::alu_op_t                  alu_op;
	logic [AW-1:0]                     alu_a;
	logic [AW-1:0]                     alu_b;
	logic [AW:0]                       alu_res;
	logic                              alu_borrow;
	logic                              alu_zero;
	logic                              fit_exact;
	logic                              fit_split;
	logic                              scan_hit;
	logic                              more;
	logic [AW-1:0]                     off_ext;

	logic                              in_fire;
	logic [fft_pkg::LEN_W-1:0]         in_len;
	logic [fft_pkg::XOFF_W-1:0]        in_off;
	logic [fft_pkg::XSIZE_W-1:0]       in_size;
	logic                              in_next_free;

	assign in_len       = s_axis_tdata[15:0];
	assign in_off       = s_axis_tdata[47:16];
	assign in_size      = s_axis_tdata[64:48];
	assign in_next_free = s_axis_tdata[65];

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign rd_off  = ram_rdata[EW-1:fft_pkg::SIZE_W];
	assign rd_size = ram_rdata[fft_pkg::SIZE_W-1:0];
	assign more    = (idx_q < count_q);

	fft_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	fft_alu #(
		.AW(AW)
	) u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.res(alu_res)
	);

	// operand selection for the shared unit
	always_comb begin
		alu_op = fft_pkg::ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_PREP: begin
				alu_a = AW'(off_in_q);
				alu_b = AW'(size_in_q);
			end
			S_SCAN: begin
				alu_op = fft_pkg::ALU_SUB;
				if (free_q) begin
					alu_a = AW'(rd_off);
					alu_b = AW'(target_q);
				end else begin
					alu_a = AW'(rd_size);
					alu_b = AW'(need_q);
				end
			end
			S_SPLIT: begin
				alu_a = AW'(offset_q);
				alu_b = AW'(need_q);
			end
			S_APPEND: begin
				alu_a = AW'(end_q);
				alu_b = AW'(need_q);
			end
			S_MERGE: begin
				alu_a = AW'(size_q);
				alu_b = AW'(size_in_q);
			end
			default: begin
				alu_op = fft_pkg::ALU_ADD;
			end
		endcase
	end

	assign alu_borrow = alu_res[AW];
	assign alu_zero   = (alu_res[AW-1:0] == '0);
	assign fit_exact  = !alu_borrow && alu_zero;
	// leftover of one to five bytes is too small to keep
	assign fit_split  = !alu_borrow && (alu_res[AW-1:0] > AW'(fft_pkg::MIN_LEFTOVER));
	assign scan_hit   = chk_q && (free_q ? fit_exact : (fit_exact || fit_split));
	assign off_ext    = AW'(rd_off);

	// ram access per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = chk_idx_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = idx_q[IW-1:0];
		case (state_q)
			S_SCAN: begin
				ram_re = more && !scan_hit;
			end
			S_SHIFT: begin
				ram_re    = more;
				ram_we    = chk_q;
				ram_waddr = chk_idx_q - IW'(1);
			end
			S_SPLIT: begin
				ram_we    = 1'b1;
				ram_waddr = hit_idx_q;
				ram_wdata = {alu_res[OW-1:0], size_q};
			end
			S_MERGE: begin
				ram_we    = 1'b1;
				ram_waddr = hit_idx_q;
				ram_wdata = {off_in_q, alu_res[fft_pkg::SIZE_W-1:0]};
			end
			S_NEWFREE: begin
				ram_we    = (count_q != CW'(TABLE_DEPTH));
				ram_waddr = count_q[IW-1:0];
				ram_wdata = {off_in_q, fft_pkg::SIZE_W'(size_in_q)};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// request fields, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			free_q    <= s_axis_tuser;
			need_q    <= {1'b0, in_len} + fft_pkg::NEED_W'(fft_pkg::HDR_BYTES);
			off_in_q  <= OW'(in_off);
			size_in_q <= in_size;
		end
		if (state_q == S_PREP) begin
			target_q <= alu_res[OW-1:0];
		end
		if (state_q == S_SCAN && scan_hit) begin
			hit_idx_q <= chk_idx_q;
			offset_q  <= rd_off;
			size_q    <= free_q ? rd_size : alu_res[fft_pkg::SIZE_W-1:0];
		end
		if ((state_q == S_SCAN && !scan_hit && more) || (state_q == S_SHIFT && more)) begin
			chk_idx_q <= idx_q[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			end_q        <= '0;
			idx_q        <= '0;
			chk_q        <= 1'b0;
			status_q     <= fft_pkg::STAT_EXACT;
			pos_q        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= fft_pkg::STAT_EXACT;
			out_pos_q    <= '0;
		end else begin
			if (out_valid_q && m_axis_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					chk_q <= 1'b0;
					pos_q <= '0;
					if (in_fire) begin
						if (!s_axis_tuser) begin
							state_q <= S_SCAN;
						end else if (in_next_free) begin
							state_q <= S_PREP;
						end else begin
							state_q <= S_NEWFREE;
						end
					end
				end
				S_PREP: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_hit) begin
						chk_q <= 1'b0;
						idx_q <= CW'(chk_idx_q) + CW'(1);
						pos_q <= off_ext[fft_pkg::POS_W-1:0];
						if (free_q) begin
							state_q <= S_MERGE;
						end else if (fit_exact) begin
							status_q <= fft_pkg::STAT_EXACT;
							state_q  <= S_SHIFT;
						end else begin
							status_q <= fft_pkg::STAT_SPLIT;
							state_q  <= S_SPLIT;
						end
					end else if (more) begin
						chk_q <= 1'b1;
						idx_q <= idx_q + CW'(1);
					end else begin
						chk_q <= 1'b0;
						if (free_q) begin
							status_q <= fft_pkg::STAT_MISSING;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_APPEND;
						end
					end
				end
				S_SHIFT: begin
					// entries behind the removed one move up by one place
					if (more) begin
						chk_q <= 1'b1;
						idx_q <= idx_q + CW'(1);
					end else begin
						chk_q <= 1'b0;
						if (!chk_q) begin
							count_q <= count_q - CW'(1);
							state_q <= S_DONE;
						end
					end
				end
				S_SPLIT: begin
					state_q <= S_DONE;
				end
				S_APPEND: begin
					end_q    <= alu_res[OW-1:0];
					pos_q    <= alu_a[fft_pkg::POS_W-1:0];
					status_q <= fft_pkg::STAT_APPEND;
					state_q  <= S_DONE;
				end
				S_MERGE: begin
					pos_q    <= '0;
					status_q <= fft_pkg::STAT_MERGED;
					state_q  <= S_DONE;
				end
				S_NEWFREE: begin
					if (count_q == CW'(TABLE_DEPTH)) begin
						status_q <= fft_pkg::STAT_FULL;
					end else begin
						count_q  <= count_q + CW'(1);
						status_q <= fft_pkg::STAT_NEWFREE;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_pos_q    <= pos_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_pos_q, out_status_q};

endmodule

// ===== rtl/core/fft_chk.sv =====
// port-level checker for the first-fit free extent table, bound to the top level
module fft_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [fft_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input logic                          s_axis_tuser,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [fft_pkg::M_TDATA_W-1:0] m_axis_tdata
);

	// result must hold while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one request at a time: busy right after an input transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a request is in progress");

	// no result appears in the cycle right after a request
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result appeared too early");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd7) && (m_axis_tdata[39:35] == 5'd0))
		else $error("bad status code or fill bits");

endmodule

bind first_fit_free_extent_table fft_chk u_fft_chk (.*);
